/* sv/vdif_header_decode_check_top_assert.svh */
// Assertion macros for the VDIF header decoder and checker.
`ifndef VDIF_HEADER_DECODE_CHECK_TOP_ASSERT_SVH
`define VDIF_HEADER_DECODE_CHECK_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define VHDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define VHDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/vdif_hdc_pkg.sv */
// Shared constants, status codes and types of the VDIF header decoder.
`timescale 1ns / 1ps
`default_nettype none

package vdif_hdc_pkg;

    localparam int HEADER_BYTES = 32;
    localparam int WORD_COUNT   = HEADER_BYTES / 4;
    localparam int COUNT_W      = $clog2(HEADER_BYTES + 1);
    localparam int LANE_W       = $clog2(HEADER_BYTES);

    localparam logic [4:0] ST_OK          = 5'd0;
    localparam logic [4:0] ST_TOO_SHORT   = 5'd1;
    localparam logic [4:0] ST_LEGACY      = 5'd2;
    localparam logic [4:0] ST_W1_RSVD     = 5'd3;
    localparam logic [4:0] ST_W2_RSVD     = 5'd4;
    localparam logic [4:0] ST_CHAN_CODE   = 5'd5;
    localparam logic [4:0] ST_NOT_COMPLEX = 5'd6;
    localparam logic [4:0] ST_THREAD      = 5'd7;
    localparam logic [4:0] ST_EDV         = 5'd8;
    localparam logic [4:0] ST_PROFILE     = 5'd9;
    localparam logic [4:0] ST_ENCODING    = 5'd10;
    localparam logic [4:0] ST_FLAGS       = 5'd11;
    localparam logic [4:0] ST_WORD7       = 5'd12;
    localparam logic [4:0] ST_SAMPLE_BITS = 5'd13;
    localparam logic [4:0] ST_FRAME_LEN   = 5'd14;
    localparam logic [4:0] ST_NCHAN       = 5'd15;
    localparam logic [4:0] ST_NPOL        = 5'd16;
    localparam logic [4:0] ST_SAMPLES     = 5'd17;

    typedef logic [WORD_COUNT-1:0][31:0] hdr_words_t;

    typedef struct packed {
        logic [4:0]  status;
        logic        invalid_flag;
        logic [29:0] epoch_seconds;
        logic [5:0]  epoch_index;
        logic [23:0] frame_in_second;
        logic [23:0] frame_length;
        logic [5:0]  sample_bits;
        logic [15:0] station;
        logic [15:0] channel_base;
        logic [7:0]  channel_count;
        logic [7:0]  pol_count;
        logic [31:0] samples_per_packet;
    } hdr_result_t;

endpackage

`default_nettype wire

/* sv/vdif_hdc_collect.sv */
// Byte collector: stores header bytes and presents the words with the current byte merged in.
`timescale 1ns / 1ps
`default_nettype none

module vdif_hdc_collect
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    consume,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    last_byte,
    output vdif_hdc_pkg::hdr_words_t     words,
    output logic                         full
);

    logic [vdif_hdc_pkg::COUNT_W-1:0] byte_count_reg;
    logic [vdif_hdc_pkg::COUNT_W-1:0] byte_count_next;
    logic [7:0] hdr_bytes_reg [vdif_hdc_pkg::HEADER_BYTES];
    logic       room;
    logic [vdif_hdc_pkg::LANE_W-1:0] lane;

    assign room = (byte_count_reg < vdif_hdc_pkg::COUNT_W'(vdif_hdc_pkg::HEADER_BYTES));
    assign lane = byte_count_reg[vdif_hdc_pkg::LANE_W-1:0];

    // The header is complete once this byte is stored or the count is already saturated.
    assign full = !room ||
        (byte_count_reg == vdif_hdc_pkg::COUNT_W'(vdif_hdc_pkg::HEADER_BYTES - 1));

    always_comb
    begin
        for (int i = 0; i < vdif_hdc_pkg::HEADER_BYTES; i++)
        begin
            if (room && (lane == vdif_hdc_pkg::LANE_W'(i)))
            begin
                words[i / 4][(i % 4) * 8 +: 8] = data_byte;
            end
            else
            begin
                words[i / 4][(i % 4) * 8 +: 8] = hdr_bytes_reg[i];
            end
        end
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        if (consume)
        begin
            if (last_byte)
            begin
                byte_count_next = '0;
            end
            else if (room)
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && room)
        begin
            hdr_bytes_reg[lane] <= data_byte;
        end
    end

endmodule

`default_nettype wire

/* sv/vdif_hdc_check.sv */
// Header checker: fixed-field checks, field unpacking and field validation.
`timescale 1ns / 1ps
`default_nettype none

module vdif_hdc_check
(
    input  wire vdif_hdc_pkg::hdr_words_t words,
    input  wire logic                     full,
    output vdif_hdc_pkg::hdr_result_t     result
);

    logic [4:0] fixed_status;
    vdif_hdc_pkg::hdr_result_t dec;

    always_comb
    begin
        if (words[0][30])
            fixed_status = vdif_hdc_pkg::ST_LEGACY;
        else if (words[1][31:30] != 2'd0)
            fixed_status = vdif_hdc_pkg::ST_W1_RSVD;
        else if (words[2][31:29] != 3'd0)
            fixed_status = vdif_hdc_pkg::ST_W2_RSVD;
        else if (words[2][28:24] != 5'd31)
            fixed_status = vdif_hdc_pkg::ST_CHAN_CODE;
        else if (!words[3][31])
            fixed_status = vdif_hdc_pkg::ST_NOT_COMPLEX;
        else if (words[3][25:16] != 10'd0)
            fixed_status = vdif_hdc_pkg::ST_THREAD;
        else if (words[4][31:24] != 8'hff)
            fixed_status = vdif_hdc_pkg::ST_EDV;
        else if (words[4][23:16] != 8'd1)
            fixed_status = vdif_hdc_pkg::ST_PROFILE;
        else if (words[4][15:8] != 8'd1)
            fixed_status = vdif_hdc_pkg::ST_ENCODING;
        else if (words[4][7:0] != 8'd0)
            fixed_status = vdif_hdc_pkg::ST_FLAGS;
        else if (words[7] != 32'd0)
            fixed_status = vdif_hdc_pkg::ST_WORD7;
        else
            fixed_status = vdif_hdc_pkg::ST_OK;
    end

    always_comb
    begin
        dec.invalid_flag       = words[0][31];
        dec.epoch_seconds      = words[0][29:0];
        dec.epoch_index        = words[1][29:24];
        dec.frame_in_second    = words[1][23:0];
        dec.frame_length       = words[2][23:0];
        dec.sample_bits        = {1'b0, words[3][30:26]} + 6'd1;
        dec.station            = words[3][15:0];
        dec.channel_base       = words[5][31:16];
        dec.channel_count      = words[5][15:8];
        dec.pol_count          = words[5][7:0];
        dec.samples_per_packet = words[6];

        if (!full)
            dec.status = vdif_hdc_pkg::ST_TOO_SHORT;
        else if (fixed_status != vdif_hdc_pkg::ST_OK)
            dec.status = fixed_status;
        else if (dec.sample_bits != 6'd8 && dec.sample_bits != 6'd16)
            dec.status = vdif_hdc_pkg::ST_SAMPLE_BITS;
        else if (dec.frame_length == 24'd0)
            dec.status = vdif_hdc_pkg::ST_FRAME_LEN;
        else if (dec.channel_count == 8'd0)
            dec.status = vdif_hdc_pkg::ST_NCHAN;
        else if (dec.pol_count != 8'd1 && dec.pol_count != 8'd2)
            dec.status = vdif_hdc_pkg::ST_NPOL;
        else if (dec.samples_per_packet == 32'd0)
            dec.status = vdif_hdc_pkg::ST_SAMPLES;
        else
            dec.status = vdif_hdc_pkg::ST_OK;
    end

    // A failed or short header reports the status alone.
    always_comb
    begin
        if (dec.status == vdif_hdc_pkg::ST_OK)
        begin
            result = dec;
        end
        else
        begin
            result        = '0;
            result.status = dec.status;
        end
    end

endmodule

`default_nettype wire

/* sv/vdif_header_decode_check_top.sv */
// Top level of the VDIF header decoder and checker.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  data_byte, last_byte
//  output   out        out_valid/out_stall  status and eleven decoded header fields
//
// One byte is taken per cycle while the input is not stalled; each byte request is held in the input register.
// The result register loads on the edge that takes a last byte out of the input register.
// The byte store holds 32 bytes; the check is one combinational pass into the result register.
// Reset clears the byte count and all valid flags; stored bytes are not cleared.
// Only a last byte waits on a stalled result register; other bytes keep flowing.
`timescale 1ns / 1ps
`default_nettype none

`include "vdif_header_decode_check_top_assert.svh"

module vdif_header_decode_check_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       status,
    output logic             invalid_flag,
    output logic [29:0]      epoch_seconds,
    output logic [5:0]       epoch_index,
    output logic [23:0]      frame_in_second,
    output logic [23:0]      frame_length,
    output logic [5:0]       sample_bits,
    output logic [15:0]      station,
    output logic [15:0]      channel_base,
    output logic [7:0]       channel_count,
    output logic [7:0]       pol_count,
    output logic [31:0]      samples_per_packet
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       consume;
    logic       out_valid_reg;
    logic       out_valid_next;
    vdif_hdc_pkg::hdr_result_t result_reg;
    vdif_hdc_pkg::hdr_result_t check_result;
    vdif_hdc_pkg::hdr_words_t  words;
    logic       full;

    // Only a held last byte can be blocked, and only by a result still waiting.
    assign in_stall = in_valid_reg && in_last_reg && out_valid_reg && out_stall;
    assign consume  = in_valid_reg && !in_stall;

    vdif_hdc_collect u_collect
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .consume   (consume),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .words     (words),
        .full      (full)
    );

    vdif_hdc_check u_check
    (
        .words  (words),
        .full   (full),
        .result (check_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (consume && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (consume && in_last_reg)
        begin
            result_reg <= check_result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = result_reg.status;
    assign invalid_flag       = result_reg.invalid_flag;
    assign epoch_seconds      = result_reg.epoch_seconds;
    assign epoch_index        = result_reg.epoch_index;
    assign frame_in_second    = result_reg.frame_in_second;
    assign frame_length       = result_reg.frame_length;
    assign sample_bits        = result_reg.sample_bits;
    assign station            = result_reg.station;
    assign channel_base       = result_reg.channel_base;
    assign channel_count      = result_reg.channel_count;
    assign pol_count          = result_reg.pol_count;
    assign samples_per_packet = result_reg.samples_per_packet;

    `VHDC_ASSERT_NEXT(a_last_gives_result, clk, rst_n,
        consume && in_last_reg, out_valid_reg,
        "last byte did not produce a result")

    `VHDC_ASSERT_NOW(a_ok_sample_bits, clk, rst_n,
        out_valid_reg && (result_reg.status == vdif_hdc_pkg::ST_OK),
        result_reg.sample_bits == 6'd8 || result_reg.sample_bits == 6'd16,
        "accepted header has bad component width")

    `VHDC_ASSERT_NOW(a_fail_clears_fields, clk, rst_n,
        out_valid_reg && (result_reg.status != vdif_hdc_pkg::ST_OK),
        result_reg.epoch_seconds == 30'd0 && result_reg.samples_per_packet == 32'd0 &&
        result_reg.sample_bits == 6'd0,
        "failed header result carries field values")

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the VDIF header decoder and checker: directed and random headers.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_BYTES = 600;
    localparam int LONG_HOLD = 400;

    // Smallest legal values in every decoded field.
    localparam vdif_hdc_pkg::hdr_words_t LO_HDR = {32'h0000_0000, 32'h0000_0001,
                                     32'h0000_0101, 32'hff01_0100, 32'h9c00_0000,
                                     32'h1f00_0001, 32'h0000_0000, 32'h0000_0000};
    // Largest legal values in every decoded field.
    localparam vdif_hdc_pkg::hdr_words_t HI_HDR = {32'h0000_0000, 32'hffff_ffff,
                                     32'hffff_ff02, 32'hff01_0100, 32'hbc00_ffff,
                                     32'h1fff_ffff, 32'h3fff_ffff, 32'hbfff_ffff};

    localparam vdif_hdc_pkg::hdr_result_t LO_RES = '{status: vdif_hdc_pkg::ST_OK,
        invalid_flag: 1'b0,
        epoch_seconds: 30'd0, epoch_index: 6'd0, frame_in_second: 24'd0,
        frame_length: 24'd1, sample_bits: 6'd8, station: 16'd0, channel_base: 16'd0,
        channel_count: 8'd1, pol_count: 8'd1, samples_per_packet: 32'd1};
    localparam vdif_hdc_pkg::hdr_result_t HI_RES = '{status: vdif_hdc_pkg::ST_OK,
        invalid_flag: 1'b1,
        epoch_seconds: 30'h3fff_ffff, epoch_index: 6'd63, frame_in_second: 24'hff_ffff,
        frame_length: 24'hff_ffff, sample_bits: 6'd16, station: 16'hffff,
        channel_base: 16'hffff, channel_count: 8'hff, pol_count: 8'd2,
        samples_per_packet: 32'hffff_ffff};

    typedef struct {
        logic [7:0]                data;
        logic                      last;
        bit                        known;
        vdif_hdc_pkg::hdr_result_t want;
        bit                        drain;
    } byte_req_t;

    typedef struct {
        vdif_hdc_pkg::hdr_words_t  w;
        int                        nbytes;
        bit                        known;
        vdif_hdc_pkg::hdr_result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  status;
    logic        invalid_flag;
    logic [29:0] epoch_seconds;
    logic [5:0]  epoch_index;
    logic [23:0] frame_in_second;
    logic [23:0] frame_length;
    logic [5:0]  sample_bits;
    logic [15:0] station;
    logic [15:0] channel_base;
    logic [7:0]  channel_count;
    logic [7:0]  pol_count;
    logic [31:0] samples_per_packet;

    byte_req_t                 stim[$];
    dir_row_t                  dir_tab[$];
    vdif_hdc_pkg::hdr_result_t pending_results[$];
    vdif_hdc_pkg::hdr_result_t head;

    // Predictor state: bytes gathered so far for the header in progress.
    int unsigned              hdr_cnt;
    vdif_hdc_pkg::hdr_words_t hdr_w;

    int unsigned cyc;
    int unsigned n_bad;
    int unsigned n_results;
    bit          long_hold_done;
    logic        quiet;

    assign quiet = (cyc >= 1500) && (cyc < 2300);

    vdif_header_decode_check_top dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .data_byte          (data_byte),
        .last_byte          (last_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .invalid_flag       (invalid_flag),
        .epoch_seconds      (epoch_seconds),
        .epoch_index        (epoch_index),
        .frame_in_second    (frame_in_second),
        .frame_length       (frame_length),
        .sample_bits        (sample_bits),
        .station            (station),
        .channel_base       (channel_base),
        .channel_count      (channel_count),
        .pol_count          (pol_count),
        .samples_per_packet (samples_per_packet)
    );

    function automatic vdif_hdc_pkg::hdr_result_t fail_with(logic [4:0] st);
        vdif_hdc_pkg::hdr_result_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic vdif_hdc_pkg::hdr_words_t with_word(vdif_hdc_pkg::hdr_words_t w,
                                                           int i, logic [31:0] v);
        vdif_hdc_pkg::hdr_words_t r;
        r = w;
        r[i] = v;
        return r;
    endfunction

    // Checks the fixed fields in order, then unpacks and checks the header fields.
    function automatic vdif_hdc_pkg::hdr_result_t decode_header(vdif_hdc_pkg::hdr_words_t w);
        vdif_hdc_pkg::hdr_result_t r;
        logic [4:0]                st;
        r = '0;
        if (w[0][30])                   r.status = vdif_hdc_pkg::ST_LEGACY;
        else if (w[1][31:30] != 2'd0)   r.status = vdif_hdc_pkg::ST_W1_RSVD;
        else if (w[2][31:29] != 3'd0)   r.status = vdif_hdc_pkg::ST_W2_RSVD;
        else if (w[2][28:24] != 5'd31)  r.status = vdif_hdc_pkg::ST_CHAN_CODE;
        else if (!w[3][31])             r.status = vdif_hdc_pkg::ST_NOT_COMPLEX;
        else if (w[3][25:16] != 10'd0)  r.status = vdif_hdc_pkg::ST_THREAD;
        else if (w[4][31:24] != 8'hff)  r.status = vdif_hdc_pkg::ST_EDV;
        else if (w[4][23:16] != 8'd1)   r.status = vdif_hdc_pkg::ST_PROFILE;
        else if (w[4][15:8] != 8'd1)    r.status = vdif_hdc_pkg::ST_ENCODING;
        else if (w[4][7:0] != 8'd0)     r.status = vdif_hdc_pkg::ST_FLAGS;
        else if (w[7] != 32'd0)         r.status = vdif_hdc_pkg::ST_WORD7;
        else
        begin
            r.invalid_flag       = w[0][31];
            r.epoch_seconds      = w[0][29:0];
            r.epoch_index        = w[1][29:24];
            r.frame_in_second    = w[1][23:0];
            r.frame_length       = w[2][23:0];
            r.sample_bits        = {1'b0, w[3][30:26]} + 6'd1;
            r.station            = w[3][15:0];
            r.channel_base       = w[5][31:16];
            r.channel_count      = w[5][15:8];
            r.pol_count          = w[5][7:0];
            r.samples_per_packet = w[6];
            if (r.sample_bits != 6'd8 && r.sample_bits != 6'd16)
                r.status = vdif_hdc_pkg::ST_SAMPLE_BITS;
            else if (r.frame_length == 24'd0)
                r.status = vdif_hdc_pkg::ST_FRAME_LEN;
            else if (r.channel_count == 8'd0)
                r.status = vdif_hdc_pkg::ST_NCHAN;
            else if (r.pol_count != 8'd1 && r.pol_count != 8'd2)
                r.status = vdif_hdc_pkg::ST_NPOL;
            else if (r.samples_per_packet == 32'd0)
                r.status = vdif_hdc_pkg::ST_SAMPLES;
            // A header that fails a field check reports only its status.
            if (r.status != vdif_hdc_pkg::ST_OK)
            begin
                st = r.status;
                r = '0;
                r.status = st;
            end
        end
        return r;
    endfunction

    function automatic vdif_hdc_pkg::hdr_words_t good_header();
        vdif_hdc_pkg::hdr_words_t w;
        logic [31:0]              n;
        w[0] = $urandom & 32'hbfff_ffff;
        w[1] = $urandom & 32'h3fff_ffff;
        w[2] = {8'h1f, 24'($urandom_range(24'hff_ffff, 1))};
        w[3] = {1'b1, ($urandom_range(1, 0) != 0) ? 5'd15 : 5'd7, 10'd0, 16'($urandom)};
        w[4] = 32'hff01_0100;
        w[5] = {16'($urandom), 8'($urandom_range(255, 1)), 8'($urandom_range(2, 1))};
        n = $urandom;
        w[6] = (n == 32'd0) ? 32'd1 : n;
        w[7] = '0;
        return w;
    endfunction

    // Queues one buffer: header bytes first, random filler beyond the header length.
    function automatic void add_header(vdif_hdc_pkg::hdr_words_t w, int nbytes, bit known,
                                       vdif_hdc_pkg::hdr_result_t want);
        byte_req_t q;
        int        i;
        for (i = 0; i < nbytes; i++)
        begin
            q.data  = (i < vdif_hdc_pkg::HEADER_BYTES) ? w[i / 4][8 * (i % 4) +: 8]
                                                       : 8'($urandom);
            q.last  = (i == nbytes - 1);
            q.known = known;
            q.want  = want;
            q.drain = 1'b0;
            stim.push_back(q);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         name, n_results, want, got);
        end
    endfunction

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    initial
    begin
        while (cyc < CYCLE_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls plus one long hold-off that lets the block back up.
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && n_results >= 12)
            begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 28);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("result %0d arrived with none expected", n_results);
            end
            else
            begin
                head = pending_results.pop_front();
                check_field("status", head.status, status);
                check_field("invalid_flag", head.invalid_flag, invalid_flag);
                check_field("epoch_seconds", head.epoch_seconds, epoch_seconds);
                check_field("epoch_index", head.epoch_index, epoch_index);
                check_field("frame_in_second", head.frame_in_second, frame_in_second);
                check_field("frame_length", head.frame_length, frame_length);
                check_field("sample_bits", head.sample_bits, sample_bits);
                check_field("station", head.station, station);
                check_field("channel_base", head.channel_base, channel_base);
                check_field("channel_count", head.channel_count, channel_count);
                check_field("pol_count", head.pol_count, pol_count);
                check_field("samples_per_packet", head.samples_per_packet,
                            samples_per_packet);
            end
        end
    end

    initial
    begin : sender
        vdif_hdc_pkg::hdr_words_t w;
        int                       nb;
        int                       pick;
        int                       wi;
        int                       bi;
        int                       i;
        int unsigned              idx;
        int unsigned              drain_at;

        clk = 1'b0;
        cyc = 0;
        n_bad = 0;
        n_results = 0;
        long_hold_done = 1'b0;
        hdr_cnt = 0;
        hdr_w = '0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= 8'd0;
        last_byte <= 1'b0;

        dir_tab.push_back('{LO_HDR, 1, 1'b1, fail_with(vdif_hdc_pkg::ST_TOO_SHORT)});
        dir_tab.push_back('{LO_HDR, 31, 1'b1, fail_with(vdif_hdc_pkg::ST_TOO_SHORT)});
        dir_tab.push_back('{LO_HDR, 32, 1'b1, LO_RES});
        dir_tab.push_back('{HI_HDR, 32, 1'b1, HI_RES});
        dir_tab.push_back('{LO_HDR, 40, 1'b1, LO_RES});
        dir_tab.push_back('{with_word(LO_HDR, 0, 32'h4000_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_LEGACY)});
        dir_tab.push_back('{with_word(LO_HDR, 1, 32'h8000_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_W1_RSVD)});
        dir_tab.push_back('{with_word(LO_HDR, 2, 32'h3f00_0001), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_W2_RSVD)});
        dir_tab.push_back('{with_word(LO_HDR, 2, 32'h1e00_0001), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_CHAN_CODE)});
        dir_tab.push_back('{with_word(LO_HDR, 3, 32'h1c00_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_NOT_COMPLEX)});
        dir_tab.push_back('{with_word(LO_HDR, 3, 32'h9c01_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_THREAD)});
        dir_tab.push_back('{with_word(LO_HDR, 4, 32'hfe01_0100), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_EDV)});
        dir_tab.push_back('{with_word(LO_HDR, 4, 32'hff02_0100), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_PROFILE)});
        dir_tab.push_back('{with_word(LO_HDR, 4, 32'hff01_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_ENCODING)});
        dir_tab.push_back('{with_word(LO_HDR, 4, 32'hff01_0180), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_FLAGS)});
        dir_tab.push_back('{with_word(LO_HDR, 7, 32'h8000_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_WORD7)});
        dir_tab.push_back('{with_word(LO_HDR, 3, 32'h8000_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_SAMPLE_BITS)});
        dir_tab.push_back('{with_word(LO_HDR, 3, 32'hfc00_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_SAMPLE_BITS)});
        dir_tab.push_back('{with_word(LO_HDR, 2, 32'h1f00_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_FRAME_LEN)});
        dir_tab.push_back('{with_word(LO_HDR, 5, 32'h0000_0001), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_NCHAN)});
        dir_tab.push_back('{with_word(LO_HDR, 5, 32'h0000_0103), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_NPOL)});
        dir_tab.push_back('{with_word(LO_HDR, 6, 32'h0000_0000), 32, 1'b1,
                            fail_with(vdif_hdc_pkg::ST_SAMPLES)});
        dir_tab.push_back('{'0, 32, 1'b1, fail_with(vdif_hdc_pkg::ST_CHAN_CODE)});
        dir_tab.push_back('{'1, 32, 1'b1, fail_with(vdif_hdc_pkg::ST_LEGACY)});
        // With several faults present, the earliest check decides the status.
        dir_tab.push_back('{with_word(with_word(LO_HDR, 0, 32'h4000_0000), 6, 32'h0), 32,
                            1'b1, fail_with(vdif_hdc_pkg::ST_LEGACY)});
        dir_tab.push_back('{good_header(), 32, 1'b0, '0});
        foreach (dir_tab[r])
            add_header(dir_tab[r].w, dir_tab[r].nbytes, dir_tab[r].known, dir_tab[r].want);

        // Mostly well-formed headers with random content, the rest damaged or cut short.
        drain_at = stim.size();
        while (stim.size() - drain_at < RANDOM_BYTES)
        begin
            w = good_header();
            nb = vdif_hdc_pkg::HEADER_BYTES;
            pick = $urandom_range(99);
            if (pick < 10)
                nb = $urandom_range(40, 33);
            else if (pick < 22)
            begin
                wi = $urandom_range(vdif_hdc_pkg::WORD_COUNT - 1, 0);
                bi = $urandom_range(31, 0);
                w[wi][bi] = ~w[wi][bi];
            end
            else if (pick < 32)
            begin
                case ($urandom_range(4, 0))
                    0: w[3][30:26] = 5'($urandom);
                    1: w[5][7:0] = 8'($urandom);
                    2: w[5][15:8] = 8'd0;
                    3: w[6] = 32'd0;
                    default: w[2][23:0] = 24'd0;
                endcase
            end
            else if (pick < 40)
                nb = $urandom_range(vdif_hdc_pkg::HEADER_BYTES - 1, 1);
            else if (pick < 45)
            begin
                for (i = 0; i < vdif_hdc_pkg::WORD_COUNT; i++)
                    w[i] = $urandom;
                nb = $urandom_range(40, 1);
            end
            add_header(w, nb, 1'b0, '0);
        end
        stim[drain_at].drain = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        idx = 0;
        while (idx < stim.size())
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                if (hdr_cnt < vdif_hdc_pkg::HEADER_BYTES)
                begin
                    hdr_w[hdr_cnt / 4][8 * (hdr_cnt % 4) +: 8] = data_byte;
                    hdr_cnt++;
                end
                if (last_byte)
                begin
                    if (stim[idx].known)
                        pending_results.push_back(stim[idx].want);
                    else if (hdr_cnt < vdif_hdc_pkg::HEADER_BYTES)
                        pending_results.push_back(fail_with(vdif_hdc_pkg::ST_TOO_SHORT));
                    else
                        pending_results.push_back(decode_header(hdr_w));
                    hdr_cnt = 0;
                end
                idx++;
            end
            // A stalled request holds its payload; otherwise pick the next one.
            if (!(in_valid && in_stall))
            begin
                if (idx < stim.size() && stim[idx].drain)
                begin
                    in_valid <= 1'b0;
                    stim[idx].drain = 1'b0;
                    do
                        @(posedge clk);
                    while (pending_results.size() != 0);
                end
                if (idx >= stim.size() || (!quiet && $urandom_range(99) < 28))
                    in_valid <= 1'b0;
                else
                begin
                    in_valid <= 1'b1;
                    data_byte <= stim[idx].data;
                    last_byte <= stim[idx].last;
                end
            end
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (n_bad == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
